[sv/ceb_pkg.sv]
// shared types and constants for the coincidence event builder
// no dependencies
`default_nettype none

package ceb_pkg;

   localparam int TIME_W    = 48;
   localparam int CHANNEL_W = 9;
   localparam int ENERGY_W  = 16;
   localparam int TOT_W     = 32;
   localparam int SUM_W     = 32;
   localparam int COUNT_W   = 10;
   localparam int WINDOW_W  = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_MULT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 32'd10000;
   localparam logic [COUNT_W-1:0]  MIN_MULT_RESET = 10'd1;

   typedef enum logic [1:0] {
      KIND_FIRST = 2'd0,
      KIND_JOIN  = 2'd1,
      KIND_CLOSE = 2'd2
   } hit_kind_type;

   typedef struct packed {
      hit_kind_type                kind;
      logic [TIME_W-1:0]           time_stamp;
      logic [CHANNEL_W-1:0]        channel;
      logic signed [ENERGY_W-1:0]  energy;
      logic [TOT_W-1:0]            tot;
   } hit_entry_type;

   typedef struct packed {
      logic signed [SUM_W-1:0]     energy;
      logic signed [SUM_W-1:0]     energy_above;
      logic [TIME_W-1:0]           tot;
      logic [COUNT_W-1:0]          hits;
      logic signed [ENERGY_W-1:0]  peak_energy;
      logic [CHANNEL_W-1:0]        peak_channel;
      logic                        accepted;
      logic [TIME_W-1:0]           start;
   } event_type;

   typedef struct packed {
      logic [COUNT_W-1:0]          min_mult;
      logic signed [ENERGY_W-1:0]  threshold;
   } back_cfg_type;

endpackage

`default_nettype wire

[sv/ceb_front.sv]
// front end: tracks the open event start time and classifies each hit
// depends on ceb_pkg
`default_nettype none

module ceb_front
   import ceb_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       hit_accept,
   input  wire logic [TIME_W-1:0]          hit_time,
   input  wire logic [CHANNEL_W-1:0]       hit_channel,
   input  wire logic signed [ENERGY_W-1:0] hit_energy,
   input  wire logic [TOT_W-1:0]           hit_tot,
   input  wire logic [WINDOW_W-1:0]        window,
   output hit_entry_type                   entry
);

   logic              open_ff, open_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic signed [TIME_W+1:0] diff;
   logic              in_window;

   always_comb begin
      diff      = $signed({2'b00, hit_time}) - $signed({2'b00, start_ff});
      in_window = diff <= $signed({{(TIME_W + 2 - WINDOW_W){1'b0}}, window});

      entry.time_stamp = hit_time;
      entry.channel    = hit_channel;
      entry.energy     = hit_energy;
      entry.tot        = hit_tot;
      if (!open_ff) begin
         entry.kind = KIND_FIRST;
      end else if (in_window) begin
         entry.kind = KIND_JOIN;
      end else begin
         entry.kind = KIND_CLOSE;
      end

      open_in  = open_ff | hit_accept;
      start_in = start_ff;
      if (hit_accept && entry.kind != KIND_JOIN) begin
         start_in = hit_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         start_ff <= '0;
      end else begin
         open_ff  <= open_in;
         start_ff <= start_in;
      end
   end

endmodule

`default_nettype wire

[sv/ceb_hit_queue.sv]
// four-deep queue of classified hits between front and back end
// depends on ceb_pkg
`default_nettype none

module ceb_hit_queue
   import ceb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  hit_entry_type push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         valid,
   output hit_entry_type pop_data
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   hit_entry_type        slots_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;
   logic                 do_push, do_pop;

   always_comb begin
      full     = count_ff == (PTR_W + 1)'(DEPTH);
      valid    = count_ff != '0;
      pop_data = slots_ff[rd_ptr_ff];
      do_push  = push && !full;
      do_pop   = pop && valid;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[sv/ceb_back.sv]
// back end: accumulates event totals and holds finished events in a result queue
// depends on ceb_pkg
`default_nettype none

module ceb_back
   import ceb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  back_cfg_type cfg,
   input  wire logic    entry_valid,
   input  hit_entry_type entry,
   output logic         entry_pop,
   output logic         res_empty,
   input  wire logic    res_pop,
   output event_type    res_data
);

   localparam logic [1:0] RES_DEPTH = 2'd2;

   logic signed [SUM_W-1:0]    energy_ff, energy_in;
   logic signed [SUM_W-1:0]    above_ff, above_in;
   logic [TIME_W-1:0]          tot_ff, tot_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic signed [ENERGY_W-1:0] peak_ff, peak_in;
   logic [CHANNEL_W-1:0]       peak_ch_ff, peak_ch_in;
   logic [TIME_W-1:0]          start_ff, start_in;

   event_type  res_slots_ff [2];
   logic       res_wr_ff, res_wr_in;
   logic       res_rd_ff, res_rd_in;
   logic [1:0] res_count_ff, res_count_in;

   logic signed [SUM_W:0]    energy_wide, above_wide;
   logic [TIME_W:0]          tot_wide;
   logic signed [SUM_W-1:0]  e_ext;
   logic                     above_thr;
   logic                     res_take, res_space, res_write;
   event_type                closing;

   always_comb begin
      e_ext     = SUM_W'(entry.energy);
      above_thr = entry.energy > cfg.threshold;

      res_empty = res_count_ff == '0;
      res_data  = res_slots_ff[res_rd_ff];
      res_take  = res_pop && !res_empty;
      res_space = (res_count_ff != RES_DEPTH) || res_take;
      entry_pop = entry_valid && (entry.kind != KIND_CLOSE || res_space);
      res_write = entry_pop && entry.kind == KIND_CLOSE;

      closing.energy       = energy_ff;
      closing.energy_above = above_ff;
      closing.tot          = tot_ff;
      closing.hits         = count_ff;
      closing.peak_energy  = peak_ff;
      closing.peak_channel = peak_ch_ff;
      closing.accepted     = count_ff >= cfg.min_mult;
      closing.start        = start_ff;

      energy_wide = {energy_ff[SUM_W-1], energy_ff} + {e_ext[SUM_W-1], e_ext};
      above_wide  = {above_ff[SUM_W-1], above_ff} + {e_ext[SUM_W-1], e_ext};
      tot_wide    = {1'b0, tot_ff} + (TIME_W + 1)'(entry.tot);

      energy_in  = energy_ff;
      above_in   = above_ff;
      tot_in     = tot_ff;
      count_in   = count_ff;
      peak_in    = peak_ff;
      peak_ch_in = peak_ch_ff;
      start_in   = start_ff;

      if (entry_pop) begin
         if (entry.kind == KIND_JOIN) begin
            // saturating accumulation
            if (energy_wide[SUM_W] != energy_wide[SUM_W-1]) begin
               energy_in = energy_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                              : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
               energy_in = energy_wide[SUM_W-1:0];
            end
            if (above_thr) begin
               if (above_wide[SUM_W] != above_wide[SUM_W-1]) begin
                  above_in = above_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                               : {1'b0, {(SUM_W-1){1'b1}}};
               end else begin
                  above_in = above_wide[SUM_W-1:0];
               end
            end
            tot_in = tot_wide[TIME_W] ? '1 : tot_wide[TIME_W-1:0];
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            if (entry.energy > peak_ff) begin
               peak_in    = entry.energy;
               peak_ch_in = entry.channel;
            end
         end else begin
            // open a new event with this hit
            energy_in  = e_ext;
            above_in   = above_thr ? e_ext : '0;
            tot_in     = TIME_W'(entry.tot);
            count_in   = COUNT_W'(1);
            peak_in    = entry.energy;
            peak_ch_in = entry.channel;
            start_in   = entry.time_stamp;
         end
      end

      res_wr_in    = res_write ? ~res_wr_ff : res_wr_ff;
      res_rd_in    = res_take ? ~res_rd_ff : res_rd_ff;
      res_count_in = res_count_ff + 2'(res_write) - 2'(res_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff    <= '0;
         above_ff     <= '0;
         tot_ff       <= '0;
         count_ff     <= '0;
         peak_ff      <= '0;
         peak_ch_ff   <= '0;
         start_ff     <= '0;
         res_wr_ff    <= 1'b0;
         res_rd_ff    <= 1'b0;
         res_count_ff <= '0;
      end else begin
         energy_ff    <= energy_in;
         above_ff     <= above_in;
         tot_ff       <= tot_in;
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         peak_ch_ff   <= peak_ch_in;
         start_ff     <= start_in;
         res_wr_ff    <= res_wr_in;
         res_rd_ff    <= res_rd_in;
         res_count_ff <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_write) begin
         res_slots_ff[res_wr_ff] <= closing;
      end
   end

endmodule

`default_nettype wire

[sv/coincidence_event_builder.sv]
// coincidence event builder: one hit beat per cycle in, one event beat per closed event out
// a hit leaves the hit queue at the edge after the one that takes it, at the earliest; the event
// it closes is on rsp_ from that same edge
// throughput is one hit per cycle; full rises only once three hits wait behind a closing hit
// that is held because the two-entry event queue is full and pop is low
// synchronous active-high reset empties both queues, closes any open event and restores
// the register defaults (window 10000, minimum multiplicity 1, threshold 0)
// depends on ceb_pkg, ceb_front, ceb_hit_queue, ceb_back
`default_nettype none

module coincidence_event_builder
   import ceb_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   output logic                             full,
   input  wire logic [TIME_W-1:0]           req_hit_time,
   input  wire logic [CHANNEL_W-1:0]        req_hit_channel,
   input  wire logic signed [ENERGY_W-1:0]  req_hit_energy,
   input  wire logic [TOT_W-1:0]            req_hit_tot,
   output logic                             empty,
   input  wire logic                        pop,
   output logic signed [SUM_W-1:0]          rsp_event_energy,
   output logic signed [SUM_W-1:0]          rsp_event_energy_above,
   output logic [TIME_W-1:0]                rsp_event_tot,
   output logic [COUNT_W-1:0]               rsp_event_hits,
   output logic signed [ENERGY_W-1:0]       rsp_peak_energy,
   output logic [CHANNEL_W-1:0]             rsp_peak_channel,
   output logic                             rsp_accepted,
   output logic [TIME_W-1:0]                rsp_event_start,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_wdata
);

   logic [WINDOW_W-1:0]        window_ff, window_in;
   logic [COUNT_W-1:0]         min_mult_ff, min_mult_in;
   logic signed [ENERGY_W-1:0] threshold_ff, threshold_in;

   logic          hit_accept;
   hit_entry_type front_entry;
   hit_entry_type back_entry;
   logic          back_valid, back_pop;
   back_cfg_type  back_cfg;
   event_type     res_data;

   always_comb begin
      csr_ready    = 1'b1;
      window_in    = window_ff;
      min_mult_in  = min_mult_ff;
      threshold_in = threshold_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW:    window_in    = csr_wdata[WINDOW_W-1:0];
            CSR_MIN_MULT:  min_mult_in  = csr_wdata[COUNT_W-1:0];
            CSR_THRESHOLD: threshold_in = csr_wdata[ENERGY_W-1:0];
            default: ;
         endcase
      end
      back_cfg.min_mult  = min_mult_ff;
      back_cfg.threshold = threshold_ff;
      hit_accept = push && !full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         min_mult_ff  <= MIN_MULT_RESET;
         threshold_ff <= '0;
      end else begin
         window_ff    <= window_in;
         min_mult_ff  <= min_mult_in;
         threshold_ff <= threshold_in;
      end
   end

   ceb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .hit_accept  (hit_accept),
      .hit_time    (req_hit_time),
      .hit_channel (req_hit_channel),
      .hit_energy  (req_hit_energy),
      .hit_tot     (req_hit_tot),
      .window      (window_ff),
      .entry       (front_entry)
   );

   ceb_hit_queue u_hit_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_entry),
      .full      (full),
      .pop       (back_pop),
      .valid     (back_valid),
      .pop_data  (back_entry)
   );

   ceb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (back_cfg),
      .entry_valid (back_valid),
      .entry       (back_entry),
      .entry_pop   (back_pop),
      .res_empty   (empty),
      .res_pop     (pop),
      .res_data    (res_data)
   );

   always_comb begin
      rsp_event_energy       = res_data.energy;
      rsp_event_energy_above = res_data.energy_above;
      rsp_event_tot          = res_data.tot;
      rsp_event_hits         = res_data.hits;
      rsp_peak_energy        = res_data.peak_energy;
      rsp_peak_channel       = res_data.peak_channel;
      rsp_accepted           = res_data.accepted;
      rsp_event_start        = res_data.start;
   end

endmodule

`default_nettype wire
